FILE: sv/pidc_pkg.sv
package pidc_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SETPOINT = 3'd0,
        REG_GAIN_P   = 3'd1,
        REG_GAIN_I   = 3'd2,
        REG_GAIN_D   = 3'd3,
        REG_OUT_MIN  = 3'd4,
        REG_OUT_MAX  = 3'd5
    } t_reg_idx;

    // Item operations
    typedef enum logic {
        OP_COMPUTE = 1'b0,
        OP_RESET   = 1'b1
    } t_op;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Divider: 32-bit dividend, two quotient bits per cycle
    localparam int unsigned DIV_W     = 32;
    localparam int unsigned DVS_W     = 16;
    localparam int unsigned DIV_STEPS = DIV_W / 2;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // Shared multiplier operand and product widths
    localparam int unsigned MUL_A_W = 32;
    localparam int unsigned MUL_B_W = 17;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [DVS_W-1:0]          MS_PER_S     = 16'd1000;
    localparam logic signed [MUL_B_W-1:0] MS_PER_S_MUL = 17'sd1000;

    typedef struct packed {
        logic                   start;
        logic [DIV_W-1:0]       dividend;
        logic [DVS_W-1:0]       divisor;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic [DIV_W-1:0]       quotient;
    } t_div_rsp;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_req;

    // Signed divide by 256, truncating toward zero
    function automatic logic signed [PROD_W-9:0] f_div256(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] biased;
        biased = x + (x[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
        return biased[PROD_W-1:8];
    endfunction

    // Saturate to the signed 32-bit range
    function automatic logic signed [31:0] f_sat32(input logic signed [PROD_W-9:0] x);
        logic signed [PROD_W-9:0] hi;
        logic signed [PROD_W-9:0] lo;
        hi = (PROD_W-8)'(32'sh7fff_ffff);
        lo = (PROD_W-8)'(-33'sd2147483648);
        if (x > hi) begin
            return 32'sh7fff_ffff;
        end else if (x < lo) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

endpackage

FILE: sv/pidc_if.sv
interface pidc_cmd_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] actual_value;
    logic        invert_error;
    logic [15:0] elapsed_ms;

    modport source (output valid, operation, actual_value, invert_error, elapsed_ms,
                    input ready);
    modport sink   (input valid, operation, actual_value, invert_error, elapsed_ms,
                    output ready);
endinterface

interface pidc_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] drive;
    logic [16:0] error_now;
    logic [31:0] p_term;
    logic [31:0] integral_now;
    logic [31:0] d_term;

    modport source (output valid, drive, error_now, p_term, integral_now, d_term,
                    input ready);
    modport sink   (input valid, drive, error_now, p_term, integral_now, d_term,
                    output ready);
endinterface

FILE: sv/pidc_mul.sv
module pidc_mul (
    input  logic                                   i_clk,
    input  pidc_pkg::t_mul_req                     i_req,
    output logic signed [pidc_pkg::PROD_W-1:0]     o_prod
);

    logic signed [pidc_pkg::PROD_W-1:0] r_prod;
    logic signed [pidc_pkg::PROD_W-1:0] n_prod;

    // Signed product, registered before use
    always_comb begin
        n_prod = pidc_pkg::PROD_W'(i_req.a) * pidc_pkg::PROD_W'(i_req.b);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

FILE: sv/pidc_div.sv
module pidc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pidc_pkg::t_div_req i_req,
    output pidc_pkg::t_div_rsp o_rsp
);

    logic                              r_busy;
    logic                              r_done;
    logic [pidc_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [pidc_pkg::DIV_W-1:0]        r_quo;
    logic [pidc_pkg::DVS_W-1:0]        r_rem;
    logic [pidc_pkg::DVS_W-1:0]        r_dvs;

    logic [pidc_pkg::DVS_W:0]          t1;
    logic [pidc_pkg::DVS_W:0]          t2;
    logic [pidc_pkg::DVS_W-1:0]        rem1;
    logic [pidc_pkg::DVS_W-1:0]        n_rem;
    logic                              ge1;
    logic                              ge2;

    // Two restoring steps per cycle
    always_comb begin
        t1    = {r_rem, r_quo[pidc_pkg::DIV_W-1]};
        ge1   = t1 >= {1'b0, r_dvs};
        rem1  = ge1 ? pidc_pkg::DVS_W'(t1 - {1'b0, r_dvs}) : t1[pidc_pkg::DVS_W-1:0];
        t2    = {rem1, r_quo[pidc_pkg::DIV_W-2]};
        ge2   = t2 >= {1'b0, r_dvs};
        n_rem = ge2 ? pidc_pkg::DVS_W'(t2 - {1'b0, r_dvs}) : t2[pidc_pkg::DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                // load operands, quotient bits shift in behind the dividend
                r_busy <= 1'b1;
                r_cnt  <= pidc_pkg::DIV_CNT_W'(pidc_pkg::DIV_STEPS - 1);
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[pidc_pkg::DIV_W-3:0], ge1, ge2};
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: sv/pid_controller_clamped.sv
// Clamped fixed-point PID controller step.
// Command channel i_cmd: a compute item (measured value, invert flag, elapsed ms)
// or a reset item that clears the integral and the previous error. Result channel
// o_res: one result per item (clamped drive, error, P term, integral, D term).
// Configuration goes through i_cfg_we/i_cfg_idx/i_cfg_data, one register per
// cycle, only while no item is in flight: the user must keep to it, the block
// does not enforce it. Writes to unused indexes are dropped. A compute item
// forms the P product, then error times elapsed_ms, divided by 1000 in the
// shared radix-4 divider and added to the integral, then the error change times
// 1000, divided by elapsed_ms unless zero, then the D and I products, sum, clamp
// and result; a reset item goes straight to the result. Five multiplications
// share one 32x17 multiplier. The block takes one item at a time: i_cmd.ready
// is high only while idle. The result stays valid and stable until o_res.ready;
// a stalled receiver holds the block and no new item is taken until the result
// transfers. Reset (synchronous, active low) clears the controller state and
// loads the register defaults (gains and setpoint zero, clamps at full range).
module pid_controller_clamped (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    pidc_cmd_if.sink                            i_cmd,
    pidc_res_if.source                          o_res,
    input  logic                                i_cfg_we,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int unsigned PW = pidc_pkg::PROD_W;
    localparam int unsigned TW = pidc_pkg::PROD_W - 8;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_MP    = 13'b0000000000010,
        S_MI    = 13'b0000000000100,
        S_D1S   = 13'b0000000001000,
        S_D1W   = 13'b0000000010000,
        S_ACC   = 13'b0000000100000,
        S_D2S   = 13'b0000001000000,
        S_D2W   = 13'b0000010000000,
        S_MD    = 13'b0000100000000,
        S_MIG   = 13'b0001000000000,
        S_SUM   = 13'b0010000000000,
        S_CLAMP = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration registers
    logic signed [15:0] r_setpoint;
    logic signed [15:0] r_gain_p;
    logic signed [15:0] r_gain_i;
    logic signed [15:0] r_gain_d;
    logic signed [15:0] r_out_min;
    logic signed [15:0] r_out_max;

    // Controller state and working registers
    logic signed [31:0] r_int;
    logic signed [16:0] r_prev;
    logic signed [16:0] r_err;
    logic signed [17:0] r_diff;
    logic        [15:0] r_ms;
    logic               r_neg;
    logic               r_dz;
    logic signed [31:0] r_p;
    logic signed [31:0] r_d;
    logic signed [TW-1:0] r_sum;
    logic signed [15:0] r_drive;

    pidc_pkg::t_mul_req mul_req;
    pidc_pkg::t_div_req div_req;
    pidc_pkg::t_div_rsp div_rsp;
    logic signed [PW-1:0] w_prod;

    logic signed [16:0]   w_err_raw;
    logic signed [16:0]   w_err_in;
    logic [PW-1:0]        w_prod_abs;
    logic signed [31:0]   w_q_signed;
    logic signed [TW-1:0] w_inc;
    logic signed [TW-1:0] w_acc;
    logic signed [TW-1:0] w_ipart;
    logic signed [TW-1:0] w_whole;
    logic signed [TW-1:0] w_min;
    logic signed [TW-1:0] w_max;

    pidc_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (w_prod)
    );

    pidc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Datapath helpers
    always_comb begin
        w_err_raw  = 17'(signed'(i_cmd.actual_value)) - 17'(r_setpoint);
        w_err_in   = i_cmd.invert_error ? -w_err_raw : w_err_raw;
        w_prod_abs = w_prod[PW-1] ? PW'(-w_prod) : PW'(w_prod);
        w_q_signed = r_neg ? -signed'(div_rsp.quotient) : signed'(div_rsp.quotient);
        w_inc      = r_neg ? -TW'(signed'({1'b0, div_rsp.quotient}))
                           :  TW'(signed'({1'b0, div_rsp.quotient}));
        w_acc      = TW'(r_int) + w_inc;
        w_ipart    = pidc_pkg::f_div256(w_prod);
        w_whole    = pidc_pkg::f_div256(PW'(r_sum));
        w_min      = TW'(r_out_min);
        w_max      = TW'(r_out_max);
    end

    // Sequencer: next state and shared unit operands
    always_comb begin
        n_state = r_state;
        mul_req = '0;
        div_req = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = (pidc_pkg::t_op'(i_cmd.operation) == pidc_pkg::OP_RESET)
                              ? S_OUT : S_MP;
                end
            end
            S_MP: begin
                mul_req.a = 32'(r_gain_p);
                mul_req.b = r_err;
                n_state   = S_MI;
            end
            S_MI: begin
                mul_req.a = 32'(r_err);
                mul_req.b = signed'({1'b0, r_ms});
                n_state   = S_D1S;
            end
            S_D1S: begin
                div_req.start    = 1'b1;
                div_req.dividend = w_prod_abs[pidc_pkg::DIV_W-1:0];
                div_req.divisor  = pidc_pkg::MS_PER_S;
                n_state          = S_D1W;
            end
            S_D1W: begin
                if (div_rsp.done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                mul_req.a = 32'(r_diff);
                mul_req.b = pidc_pkg::MS_PER_S_MUL;
                n_state   = S_D2S;
            end
            S_D2S: begin
                if (r_ms != '0) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = w_prod_abs[pidc_pkg::DIV_W-1:0];
                    div_req.divisor  = r_ms;
                    n_state          = S_D2W;
                end else begin
                    n_state = S_MD;
                end
            end
            S_D2W: begin
                if (div_rsp.done) begin
                    n_state = S_MD;
                end
            end
            S_MD: begin
                mul_req.a = r_dz ? '0 : w_q_signed;
                mul_req.b = 17'(r_gain_d);
                n_state   = S_MIG;
            end
            S_MIG: begin
                mul_req.a = r_int;
                mul_req.b = 17'(r_gain_i);
                n_state   = S_SUM;
            end
            S_SUM: begin
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_int      <= '0;
            r_prev     <= '0;
            r_setpoint <= '0;
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
            r_out_min  <= 16'sh8000;
            r_out_max  <= 16'sh7fff;
        end else begin
            r_state <= n_state;

            // Register writes
            if (i_cfg_we) begin
                unique case (pidc_pkg::t_reg_idx'(i_cfg_idx))
                    pidc_pkg::REG_SETPOINT: r_setpoint <= signed'(i_cfg_data);
                    pidc_pkg::REG_GAIN_P:   r_gain_p   <= signed'(i_cfg_data);
                    pidc_pkg::REG_GAIN_I:   r_gain_i   <= signed'(i_cfg_data);
                    pidc_pkg::REG_GAIN_D:   r_gain_d   <= signed'(i_cfg_data);
                    pidc_pkg::REG_OUT_MIN:  r_out_min  <= signed'(i_cfg_data);
                    pidc_pkg::REG_OUT_MAX:  r_out_max  <= signed'(i_cfg_data);
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        if (pidc_pkg::t_op'(i_cmd.operation) == pidc_pkg::OP_RESET) begin
                            // clear accumulated state, result is all zero
                            r_int   <= '0;
                            r_prev  <= '0;
                            r_err   <= '0;
                            r_p     <= '0;
                            r_d     <= '0;
                            r_drive <= '0;
                        end else begin
                            r_err <= w_err_in;
                            r_ms  <= i_cmd.elapsed_ms;
                        end
                    end
                end
                S_MP: begin
                    r_diff <= 18'(r_err) - 18'(r_prev);
                end
                S_MI: begin
                    r_p <= pidc_pkg::f_sat32(w_ipart);
                end
                S_D1S: begin
                    r_neg <= w_prod[PW-1];
                end
                S_ACC: begin
                    r_int <= pidc_pkg::f_sat32(w_acc);
                end
                S_D2S: begin
                    r_neg <= w_prod[PW-1];
                    r_dz  <= (r_ms == '0);
                end
                S_MIG: begin
                    r_d <= pidc_pkg::f_sat32(w_ipart);
                end
                S_SUM: begin
                    // P + I part + D, exact
                    r_sum <= TW'(r_p) + w_ipart + TW'(r_d);
                end
                S_CLAMP: begin
                    // lower clamp takes priority
                    if (w_whole < w_min) begin
                        r_drive <= r_out_min;
                    end else if (w_whole > w_max) begin
                        r_drive <= r_out_max;
                    end else begin
                        r_drive <= w_whole[15:0];
                    end
                    r_prev <= r_err;
                end
                default: ;
            endcase
        end
    end

    assign i_cmd.ready        = (r_state == S_IDLE);
    assign o_res.valid        = (r_state == S_OUT);
    assign o_res.drive        = r_drive;
    assign o_res.error_now    = r_err;
    assign o_res.p_term       = r_p;
    assign o_res.integral_now = r_int;
    assign o_res.d_term       = r_d;

endmodule

FILE: sv/pidc_chk.sv
module pidc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cmd_valid,
    input logic        i_cmd_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [15:0] i_res_drive,
    input logic [31:0] i_res_integral_now
);

    // No new item while a result is pending
    a_busy_when_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !i_cmd_ready)
        else $error("command ready while result pending");

    // One item at a time: ready drops after a transfer
    a_ready_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && i_cmd_ready) |=> !i_cmd_ready)
        else $error("command ready right after transfer");

    // Valid drops after a result transfer, so a result is not given twice
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_ready) |=> !i_res_valid)
        else $error("result valid again after transfer");

    // Stalled result stays valid and holds its drive and integral
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_res_drive) && $stable(i_res_integral_now)))
        else $error("stalled result changed");

    // Reset leaves no result pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

endmodule

bind pid_controller_clamped pidc_chk u_pidc_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_cmd_valid        (i_cmd.valid),
    .i_cmd_ready        (i_cmd.ready),
    .i_res_valid        (o_res.valid),
    .i_res_ready        (o_res.ready),
    .i_res_drive        (o_res.drive),
    .i_res_integral_now (o_res.integral_now)
);
